// ===== hw/rtl/art_pkg.sv =====
package art_pkg;

  localparam int unsigned ID_W      = 32;
  localparam int unsigned KIND_W    = 8;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned RETRY_W   = 8;
  localparam int unsigned TMO_W     = 16;
  localparam int unsigned LIMIT_W   = 5;
  localparam int unsigned CFG_IDX_W = 4;

  // Most results a single collect request may produce.
  localparam logic [LIMIT_W-1:0] RESULT_CAP = 5'd16;

  localparam logic [TMO_W-1:0]   ACK_TIMEOUT_RST = 16'd1000;
  localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST = 8'd3;

  localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT = 4'd1;

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_CHECK   = 2'd2,
    OP_COLLECT = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISS    = 2'd1,
    ST_EXHAUST = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic [ID_W-1:0]    message_id;
    logic [KIND_W-1:0]  message_kind;
    logic [TIME_W-1:0]  now_ms;
    logic [LIMIT_W-1:0] collect_limit;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       retransmit_needed;
    logic [3:0] slot_index;
    logic       slot_valid;
    logic       timeout_flag;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [TMO_W-1:0]     wdata;
  } cfg_item_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [KIND_W-1:0]  kind;
    logic [TIME_W-1:0]  sent_at;
    logic [RETRY_W-1:0] retries;
  } entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic start;
    logic eval;
    logic step;
    logic emit_mid;
    logic emit_final;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic hit;
    logic found;
    logic pend_vld;
    logic found_stop;
    logic last_slot;
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/art_chan_if.sv =====
interface art_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/art_ram.sv =====
module art_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/art_dpath.sv =====
module art_dpath #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  art_pkg::cmd_t       cmd,
  output art_pkg::sts_t       sts,
  input  art_pkg::in_item_t   in_data,
  input  logic                cfg_we,
  input  art_pkg::cfg_item_t  cfg_data,
  output logic                out_valid,
  input  logic                out_ready,
  output art_pkg::out_item_t  out_data
);

  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  art_pkg::op_t                      op_r;
  logic [art_pkg::ID_W-1:0]          id_r;
  logic [art_pkg::KIND_W-1:0]        kind_r;
  logic [art_pkg::TIME_W-1:0]        now_r;
  logic [art_pkg::LIMIT_W-1:0]       lim_r;
  logic [art_pkg::LIMIT_W-1:0]       cnt_r;
  logic [IDX_W-1:0]                  idx_r;
  logic                              pend_vld_r;
  logic [IDX_W-1:0]                  pend_idx_r;
  logic                              hit_r;
  art_pkg::status_t                  res_status_r;
  logic [IDX_W-1:0]                  res_idx_r;
  logic                              free_vld_r;
  logic [IDX_W-1:0]                  free_idx_r;
  logic                              retx_r;
  logic                              flag_r;
  logic [SLOTS-1:0]                  active_r;
  logic [art_pkg::TMO_W-1:0]         tmo_r;
  logic [art_pkg::RETRY_W-1:0]       rlim_r;
  logic                              out_valid_r;
  art_pkg::out_item_t                out_data_r;

  art_pkg::entry_t                   rd_entry;
  art_pkg::entry_t                   ram_wdata;
  logic [IDX_W-1:0]                  ram_waddr;
  logic                              ram_we;

  logic                              act;
  logic                              id_eq;
  logic                              kind_eq;
  logic [art_pkg::TIME_W-1:0]        elapsed;
  logic                              timed;
  logic [art_pkg::RETRY_W-1:0]       ret_inc;
  logic                              exhaust;
  logic                              hit;
  logic                              found;
  logic                              claim;
  logic                              out_free;
  logic [art_pkg::LIMIT_W-1:0]       lim_eff;
  art_pkg::out_item_t                final_item;
  art_pkg::out_item_t                mid_item;

  function automatic logic [3:0] slot4(input logic [IDX_W-1:0] x);
    logic [IDX_W+3:0] ext;
    ext = {4'b0, x};
    return ext[3:0];
  endfunction

  art_ram #(
    .WIDTH ($bits(art_pkg::entry_t)),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r),
    .rdata (rd_entry)
  );

  always_comb begin
    act      = active_r[idx_r];
    id_eq    = (rd_entry.id == id_r);
    kind_eq  = (rd_entry.kind == kind_r);
    elapsed  = now_r - rd_entry.sent_at;
    timed    = act && (elapsed >= {16'd0, tmo_r});
    ret_inc  = (rd_entry.retries == 8'hFF) ? 8'hFF : rd_entry.retries + 8'd1;
    exhaust  = timed && (ret_inc >= rlim_r);
    found    = (op_r == art_pkg::OP_COLLECT) && act &&
               (rd_entry.retries != '0) && (cnt_r < lim_r);
    case (op_r)
      art_pkg::OP_ADD:    hit = act && id_eq && kind_eq;
      art_pkg::OP_REMOVE: hit = act && id_eq;
      art_pkg::OP_CHECK:  hit = exhaust;
      default:            hit = 1'b0;
    endcase
    out_free = !out_valid_r || out_ready;
    claim    = cmd.emit_final && (op_r == art_pkg::OP_ADD) && !hit_r && free_vld_r;
    lim_eff  = (in_data.collect_limit > art_pkg::RESULT_CAP) ?
               art_pkg::RESULT_CAP : in_data.collect_limit;
  end

  assign sts.hit        = hit;
  assign sts.found      = found;
  assign sts.pend_vld   = pend_vld_r;
  assign sts.found_stop = ((cnt_r + 5'd1) == lim_r);
  assign sts.last_slot  = (idx_r == LAST_IDX);
  assign sts.out_free   = out_free;

  // Table writes: refresh or retry update during the scan, claim at the end of an add.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = rd_entry;
    if (claim) begin
      ram_we    = 1'b1;
      ram_waddr = free_idx_r;
      ram_wdata = '{id: id_r, kind: kind_r, sent_at: now_r, retries: '0};
    end else if (cmd.eval) begin
      if ((op_r == art_pkg::OP_ADD) && hit) begin
        ram_we            = 1'b1;
        ram_wdata.sent_at = now_r;
      end else if ((op_r == art_pkg::OP_CHECK) && timed) begin
        ram_we            = 1'b1;
        ram_wdata.retries = ret_inc;
        if (!exhaust) begin
          ram_wdata.sent_at = now_r;
        end
      end
    end
  end

  always_comb begin
    final_item              = '0;
    final_item.timeout_flag = flag_r;
    final_item.last         = 1'b1;
    if (hit_r) begin
      final_item.status     = res_status_r;
      final_item.slot_index = slot4(res_idx_r);
      final_item.slot_valid = 1'b1;
    end else begin
      case (op_r)
        art_pkg::OP_ADD: begin
          if (free_vld_r) begin
            final_item.status     = art_pkg::ST_OK;
            final_item.slot_index = slot4(free_idx_r);
            final_item.slot_valid = 1'b1;
          end else begin
            final_item.status = art_pkg::ST_MISS;
          end
        end
        art_pkg::OP_REMOVE: final_item.status = art_pkg::ST_MISS;
        art_pkg::OP_CHECK: begin
          final_item.status            = art_pkg::ST_OK;
          final_item.retransmit_needed = retx_r;
        end
        art_pkg::OP_COLLECT: begin
          final_item.status     = art_pkg::ST_OK;
          final_item.slot_index = pend_vld_r ? slot4(pend_idx_r) : 4'd0;
          final_item.slot_valid = pend_vld_r;
        end
        default: final_item.status = art_pkg::ST_OK;
      endcase
    end
    mid_item              = '0;
    mid_item.status       = art_pkg::ST_OK;
    mid_item.slot_index   = slot4(pend_idx_r);
    mid_item.slot_valid   = 1'b1;
    mid_item.timeout_flag = flag_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r   <= art_pkg::op_t'(in_data.operation);
      id_r   <= in_data.message_id;
      kind_r <= in_data.message_kind;
      now_r  <= in_data.now_ms;
      lim_r  <= lim_eff;
    end
    if (cmd.eval && hit) begin
      res_idx_r <= idx_r;
      case (op_r)
        art_pkg::OP_CHECK: res_status_r <= art_pkg::ST_EXHAUST;
        default:           res_status_r <= art_pkg::ST_OK;
      endcase
    end
    if (cmd.eval && (op_r == art_pkg::OP_ADD) && !act && !free_vld_r) begin
      free_idx_r <= idx_r;
    end
    if (cmd.emit_mid || (cmd.eval && found && !pend_vld_r)) begin
      pend_idx_r <= idx_r;
    end
    if (cmd.emit_mid) begin
      out_data_r <= mid_item;
    end else if (cmd.emit_final) begin
      out_data_r <= final_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      cnt_r       <= '0;
      pend_vld_r  <= 1'b0;
      hit_r       <= 1'b0;
      free_vld_r  <= 1'b0;
      retx_r      <= 1'b0;
      flag_r      <= 1'b0;
      active_r    <= '0;
      tmo_r       <= art_pkg::ACK_TIMEOUT_RST;
      rlim_r      <= art_pkg::RETRY_LIMIT_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_data.index)
          art_pkg::REG_ACK_TIMEOUT: tmo_r  <= cfg_data.wdata;
          art_pkg::REG_RETRY_LIMIT: rlim_r <= cfg_data.wdata[7:0];
          default: ;
        endcase
      end
      if (cmd.start) begin
        idx_r      <= '0;
        cnt_r      <= '0;
        pend_vld_r <= 1'b0;
        hit_r      <= 1'b0;
        free_vld_r <= 1'b0;
        retx_r     <= 1'b0;
      end else begin
        if (cmd.step) begin
          idx_r <= idx_r + 1'b1;
        end
        if (cmd.eval) begin
          if (hit) begin
            hit_r <= 1'b1;
          end
          if ((op_r == art_pkg::OP_ADD) && !act) begin
            free_vld_r <= 1'b1;
          end
          if ((op_r == art_pkg::OP_REMOVE) && hit) begin
            active_r[idx_r] <= 1'b0;
          end
          if ((op_r == art_pkg::OP_CHECK) && timed) begin
            if (exhaust) begin
              flag_r <= 1'b1;
            end else begin
              retx_r <= 1'b1;
            end
          end
          if (found && !pend_vld_r) begin
            pend_vld_r <= 1'b1;
            cnt_r      <= cnt_r + 5'd1;
          end
        end
        if (cmd.emit_mid) begin
          cnt_r <= cnt_r + 5'd1;
        end
        if (claim) begin
          active_r[free_idx_r] <= 1'b1;
        end
      end
      if (cmd.emit_mid || cmd.emit_final) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_flag_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    flag_r |=> flag_r)
    else $error("exhausted flag cleared outside reset");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_mid || cmd.emit_final) |-> out_free)
    else $error("result loaded over one not yet taken");

  a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_final |-> (cnt_r <= lim_r))
    else $error("collect produced more slots than its limit");

  a_claim_free: assert property (@(posedge clk) disable iff (!rst_n)
    claim |-> !active_r[free_idx_r])
    else $error("add claimed a slot that is already active");

endmodule

// ===== hw/rtl/art_ctrl.sv =====
module art_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  art_pkg::sts_t sts,
  output art_pkg::cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_EVAL  = 5'b00100,
    S_EMIT  = 5'b01000,
    S_FINAL = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   step;

  always_comb begin
    state_nxt = state_r;
    step      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_READ;
        end
      end
      S_READ: state_nxt = S_EVAL;
      S_EVAL: begin
        if (sts.hit) begin
          state_nxt = S_FINAL;
        end else if (sts.found && sts.pend_vld) begin
          // An earlier slot is held back until we know it is not the last one.
          state_nxt = S_EMIT;
        end else if ((sts.found && sts.found_stop) || sts.last_slot) begin
          state_nxt = S_FINAL;
        end else begin
          state_nxt = S_READ;
          step      = 1'b1;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          if (sts.found_stop || sts.last_slot) begin
            state_nxt = S_FINAL;
          end else begin
            state_nxt = S_READ;
            step      = 1'b1;
          end
        end
      end
      S_FINAL: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready       = (state_r == S_IDLE);
  assign cmd.start      = in_valid && (state_r == S_IDLE);
  assign cmd.eval       = (state_r == S_EVAL);
  assign cmd.step       = step;
  assign cmd.emit_mid   = (state_r == S_EMIT) && sts.out_free;
  assign cmd.emit_final = (state_r == S_FINAL) && sts.out_free;

endmodule

// ===== hw/rtl/ack_retry_tracker.sv =====
// Acknowledgement retry tracker: a table of SLOTS messages awaiting an ack.
// Requests arrive on in_req (valid/ready): operation add/refresh, remove,
// check timeouts or collect retried slots, with id, kind, time and limit.
// Results leave on out_rsp (valid/ready); every request gives one result,
// except collect, which gives one per retried slot (up to its limit, capped
// at 16; one without a slot if none), the final one marked by last.
// Register writes arrive on cfg_wr (always ready) and are meant to be issued
// only while no request is in flight. Each slot is scanned in two steps:
// a registered read of the entry memory, then compare and update. A request
// that scans the whole table then loads its final result into the output
// register; add, remove and check stop at the first hit. Collect passes
// through an extra emit step for each result before its last one. A new
// request can be accepted from the cycle after the final result is loaded,
// never while one is still in flight. Reset clears the active marks, the
// sticky timeout flag and the output valid bit, and loads ack_timeout = 1000
// and retry_limit = 3. When the receiver stalls, the result waits in the
// output register and the scan pauses before producing the next result.
module ack_retry_tracker #(
  parameter int unsigned SLOTS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  art_chan_if.sink   in_req,
  art_chan_if.source out_rsp,
  art_chan_if.sink   cfg_wr
);

  art_pkg::cmd_t cmd;
  art_pkg::sts_t sts;

  assign cfg_wr.ready = 1'b1;

  art_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  art_dpath #(
    .SLOTS (SLOTS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_req.data),
    .cfg_we    (cfg_wr.valid),
    .cfg_data  (cfg_wr.data),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .out_data  (out_rsp.data)
  );

endmodule

// ===== tb/sv/tb_ack_retry_tracker.sv =====
`timescale 1ns / 100ps

import art_pkg::*;

// Mirrors the slot table and the registers, and holds the results that the
// block still owes, oldest first.
class tracker_mirror #(int SLOTS = 16);
  bit              active [SLOTS];
  logic [31:0]     ids [SLOTS];
  logic [7:0]      kinds [SLOTS];
  logic [31:0]     sent_at [SLOTS];
  logic [7:0]      retries [SLOTS];
  bit              exhausted;
  logic [15:0]     ack_timeout;
  logic [7:0]      retry_limit;
  out_item_t       owed [$];
  int              mismatches;

  function new();
    foreach (active[i]) active[i] = 1'b0;
    exhausted   = 1'b0;
    ack_timeout = ACK_TIMEOUT_RST;
    retry_limit = RETRY_LIMIT_RST;
    mismatches  = 0;
  endfunction

  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
    if (idx == REG_ACK_TIMEOUT) ack_timeout = value;
    else if (idx == REG_RETRY_LIMIT) retry_limit = value[7:0];
  endfunction

  function void owe(status_t st, logic retx, int slot, logic vld, logic fin);
    out_item_t r;
    r.status            = st;
    r.retransmit_needed = retx;
    r.slot_index        = vld ? slot[3:0] : 4'd0;
    r.slot_valid        = vld;
    r.timeout_flag      = exhausted;
    r.last              = fin;
    owed.push_back(r);
  endfunction

  function void note_request(in_item_t req);
    logic [31:0] elapsed;
    logic        retx;
    int          lim;
    int          hits [$];
    case (op_t'(req.operation))
      OP_ADD: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (active[i] && ids[i] == req.message_id && kinds[i] == req.message_kind) begin
            sent_at[i] = req.now_ms;
            owe(ST_OK, 1'b0, i, 1'b1, 1'b1);
            return;
          end
        end
        for (int i = 0; i < SLOTS; i++) begin
          if (!active[i]) begin
            active[i]  = 1'b1;
            ids[i]     = req.message_id;
            kinds[i]   = req.message_kind;
            sent_at[i] = req.now_ms;
            retries[i] = 8'd0;
            owe(ST_OK, 1'b0, i, 1'b1, 1'b1);
            return;
          end
        end
        owe(ST_MISS, 1'b0, 0, 1'b0, 1'b1);
      end
      OP_REMOVE: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (active[i] && ids[i] == req.message_id) begin
            active[i] = 1'b0;
            owe(ST_OK, 1'b0, i, 1'b1, 1'b1);
            return;
          end
        end
        owe(ST_MISS, 1'b0, 0, 1'b0, 1'b1);
      end
      OP_CHECK: begin
        retx = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
          if (!active[i]) continue;
          elapsed = req.now_ms - sent_at[i];
          if (elapsed < ack_timeout) continue;
          if (retries[i] != 8'hFF) retries[i] += 8'd1;
          // Hitting the limit ends the scan; slots rearmed so far stay rearmed.
          if (retries[i] >= retry_limit) begin
            exhausted = 1'b1;
            owe(ST_EXHAUST, 1'b0, i, 1'b1, 1'b1);
            return;
          end
          sent_at[i] = req.now_ms;
          retx       = 1'b1;
        end
        owe(ST_OK, retx, 0, 1'b0, 1'b1);
      end
      default: begin
        lim = (req.collect_limit > RESULT_CAP) ? RESULT_CAP : req.collect_limit;
        for (int i = 0; i < SLOTS && hits.size() < lim; i++)
          if (active[i] && retries[i] != 8'd0) hits.push_back(i);
        if (hits.size() == 0) owe(ST_OK, 1'b0, 0, 1'b0, 1'b1);
        else foreach (hits[k]) owe(ST_OK, 1'b0, hits[k], 1'b1, k == hits.size() - 1);
      end
    endcase
  endfunction

  function void compare(string field, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endfunction

  function void check_result(out_item_t got);
    out_item_t want;
    if (owed.size() == 0) begin
      $display("%0t: result with nothing pending, expected none, actual status %0d slot %0d",
               $time, got.status, got.slot_index);
      mismatches++;
      return;
    end
    want = owed.pop_front();
    compare("status", want.status, got.status);
    compare("retransmit_needed", want.retransmit_needed, got.retransmit_needed);
    compare("slot_index", want.slot_index, got.slot_index);
    compare("slot_valid", want.slot_valid, got.slot_valid);
    compare("timeout_flag", want.timeout_flag, got.timeout_flag);
    compare("last", want.last, got.last);
  endfunction
endclass

module tb_ack_retry_tracker;

  localparam int N_SLOTS     = 16;
  localparam int CLK_PERIOD  = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_ITEMS = 65;
  // No register lives at this index; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 4'hF;

  logic clk = 1'b0;
  logic rst_n;

  art_chan_if #(.T(in_item_t))  in_req ();
  art_chan_if #(.T(out_item_t)) out_rsp ();
  art_chan_if #(.T(cfg_item_t)) cfg_wr ();

  ack_retry_tracker #(.SLOTS(N_SLOTS)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp),
    .cfg_wr  (cfg_wr)
  );

  tracker_mirror #(N_SLOTS) mirror;

  logic [31:0] id_pool [12];
  logic [7:0]  kind_pool [3];
  logic [31:0] wall_ms;
  int          tx_calm = 0;
  int          rx_calm = 0;
  bit          squeeze_pending = 1'b0;
  int          stalled_cycles = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Mostly a random idle gap, with occasional runs of back-to-back traffic.
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(6, 30);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  function automatic in_item_t make_req(op_t op, logic [31:0] id, logic [7:0] kind,
                                        logic [31:0] now, logic [4:0] lim);
    in_item_t r;
    r.operation     = op;
    r.message_id    = id;
    r.message_kind  = kind;
    r.now_ms        = now;
    r.collect_limit = lim;
    return r;
  endfunction

  task automatic issue(input in_item_t req);
    int gap;
    gap = draw_gap(tx_calm);
    if (gap > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req.valid <= 1'b1;
    in_req.data  <= req;
    @(posedge clk);
    while (!(in_req.valid && in_req.ready)) @(posedge clk);
    mirror.note_request(req);
  endtask

  task automatic wait_drained();
    in_req.valid <= 1'b0;
    while (mirror.owed.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
    cfg_item_t w;
    w.index = idx;
    w.wdata = value;
    cfg_wr.valid <= 1'b1;
    cfg_wr.data  <= w;
    @(posedge clk);
    while (!(cfg_wr.valid && cfg_wr.ready)) @(posedge clk);
    mirror.set_reg(idx, value);
  endtask

  task automatic set_phase(logic [15:0] tmo, logic [7:0] rlim);
    wait_drained();
    write_reg(REG_ACK_TIMEOUT, tmo);
    write_reg(REG_RETRY_LIMIT, {8'($urandom()), rlim});
    write_reg(REG_SPARE, 16'($urandom()));
    cfg_wr.valid <= 1'b0;
  endtask

  task automatic random_phase(int count);
    in_item_t   req;
    int         roll;
    logic [4:0] lim;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if ($urandom_range(0, 15) == 0) wall_ms += $urandom();
      else wall_ms += $urandom_range(0, (mirror.ack_timeout >> 1) + 2);
      lim = ($urandom_range(0, 5) == 0) ? 5'($urandom_range(17, 31))
                                        : 5'($urandom_range(0, 16));
      if (roll < 40)
        req = make_req(OP_ADD, id_pool[$urandom_range(0, 11)],
                       kind_pool[$urandom_range(0, 2)], wall_ms, lim);
      else if (roll < 58)
        req = make_req(OP_REMOVE,
                       ($urandom_range(0, 7) == 0) ? $urandom() : id_pool[$urandom_range(0, 11)],
                       8'($urandom()), wall_ms, lim);
      else if (roll < 82)
        req = make_req(OP_CHECK, $urandom(), 8'($urandom()), wall_ms, lim);
      else if (roll < 95)
        req = make_req(OP_COLLECT, $urandom(), 8'($urandom()), wall_ms, lim);
      else
        req = make_req(op_t'($urandom_range(0, 3)), $urandom(), 8'($urandom()),
                       $urandom(), 5'($urandom()));
      issue(req);
    end
  endtask

  // Result side: random readiness, plus one long hold-off when requested.
  initial begin : drain_results
    int gap;
    out_rsp.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    gap = draw_gap(rx_calm);
    forever begin
      if (gap > 0) begin
        out_rsp.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_rsp.ready <= 1'b1;
      @(posedge clk);
      while (!(out_rsp.valid && out_rsp.ready)) @(posedge clk);
      mirror.check_result(out_rsp.data);
      if (squeeze_pending) begin
        squeeze_pending = 1'b0;
        gap = HOLD_CYCLES;
      end else begin
        gap = draw_gap(rx_calm);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_req.valid && in_req.ready) || (out_rsp.valid && out_rsp.ready) ||
        (cfg_wr.valid && cfg_wr.ready))
      stalled_cycles <= 0;
    else
      stalled_cycles <= stalled_cycles + 1;
    if (stalled_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic [15:0] tmo_set [7];
    logic [7:0]  lim_set [7];
    tmo_set = '{16'd65535, 16'd1, 16'd50, 16'd0, 16'd700, 16'd0, 16'd1};
    lim_set = '{8'd255, 8'd255, 8'd200, 8'd255, 8'd4, 8'd0, 8'd1};
    mirror = new();
    rst_n        <= 1'b0;
    in_req.valid <= 1'b0;
    in_req.data  <= '0;
    cfg_wr.valid <= 1'b0;
    cfg_wr.data  <= '0;
    foreach (id_pool[i]) id_pool[i] = $urandom();
    foreach (kind_pool[i]) kind_pool[i] = 8'($urandom());
    wall_ms = $urandom();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table, miss on remove, claim, refresh, kind mismatch and free.
    issue(make_req(OP_COLLECT, 32'h0, 8'h00, 32'h0, RESULT_CAP));
    issue(make_req(OP_REMOVE, 32'h1234_5678, 8'h00, 32'h0, 5'd0));
    issue(make_req(OP_ADD, 32'h0, 8'h00, 32'h0, 5'd0));
    issue(make_req(OP_ADD, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 5'h1F));
    issue(make_req(OP_ADD, 32'h0, 8'h00, 32'd5, 5'd0));
    issue(make_req(OP_ADD, 32'h0, 8'hFF, 32'd10, 5'd0));
    issue(make_req(OP_REMOVE, 32'h0, 8'h33, 32'd12, 5'd0));
    // One below the timeout across the 32-bit wrap, then exactly at it for another slot.
    issue(make_req(OP_CHECK, 32'h0, 8'h00, 32'd998, 5'd0));
    issue(make_req(OP_CHECK, 32'h0, 8'h00, 32'd1010, 5'd0));
    issue(make_req(OP_COLLECT, 32'h0, 8'h00, 32'd1011, 5'd0));
    issue(make_req(OP_COLLECT, 32'h0, 8'h00, 32'd1012, 5'h1F));
    issue(make_req(OP_COLLECT, 32'h0, 8'h00, 32'd1013, 5'd1));
    for (int k = 0; k < 14; k++)
      issue(make_req(OP_ADD, id_pool[k % 12], kind_pool[k / 12], 32'd1100 + k, 5'd0));
    issue(make_req(OP_ADD, 32'hA5A5_0F0F, 8'h77, 32'd1200, 5'd0));

    for (int p = 0; p < 7; p++) begin
      set_phase(tmo_set[p], lim_set[p]);
      if (p == 0 || p == 4) squeeze_pending = 1'b1;
      if (tmo_set[p] == 16'd0 && lim_set[p] == 8'd0) begin
        // With both registers zero, the first active slot exhausts at once.
        issue(make_req(OP_ADD, id_pool[0], kind_pool[0], wall_ms, 5'd0));
        issue(make_req(OP_CHECK, 32'h0, 8'h00, wall_ms, 5'd0));
        issue(make_req(OP_COLLECT, 32'h0, 8'h00, wall_ms, RESULT_CAP));
      end
      random_phase(PHASE_ITEMS);
    end

    wait_drained();
    repeat (2 * N_SLOTS + 4) @(posedge clk);
    if (mirror.mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== ack_retry_tracker.f =====
hw/rtl/art_pkg.sv
hw/rtl/art_chan_if.sv
hw/rtl/art_ram.sv
hw/rtl/art_dpath.sv
hw/rtl/art_ctrl.sv
hw/rtl/ack_retry_tracker.sv
tb/sv/tb_ack_retry_tracker.sv
